// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the square-free radical split
// Field widths, register reset values, register indexes and the status
// struct that the serial divider returns to the sequencer.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // field widths
    localparam int unsigned RadW   = 24;   // radicand fields, m
    localparam int unsigned DenW   = 14;   // accepted denominator, q
    localparam int unsigned CoefW  = 13;   // k
    localparam int unsigned RootW  = 13;   // trial divisor d
    localparam int unsigned ProdW  = RadW + DenW;
    localparam int unsigned DivCntW = $clog2(RadW + 1);

    // register reset values
    localparam logic [RadW-1:0] RadLimitReset = RadW'(1000000);
    localparam logic [DenW-1:0] DenLimitReset = DenW'(10000);

    // register indexes
    typedef enum logic [0:0] {
        CFG_RADICAND_LIMIT    = 1'b0,
        CFG_DENOMINATOR_LIMIT = 1'b1
    } t_cfg_index;

    // result status codes
    typedef enum logic [0:0] {
        ST_DONE     = 1'b0,
        ST_REJECTED = 1'b1
    } t_status;

    // divider status toward the sequencer
    typedef struct packed {
        logic            busy;
        logic [RadW-1:0] quotient;
        logic [RadW-1:0] remainder;
    } t_div_stat;

endpackage

// File: hw/rtl/sfr_mul.sv
// ----------------------------------------------------------------------------
// sfr_mul: shared registered multiplier
// One 24 x 14 bit multiply per cycle, product registered. Used for p*q,
// for the square of the trial divisor and for growing the coefficient.
// ----------------------------------------------------------------------------
module sfr_mul (
    input  logic                       i_clk,
    input  logic [sfr_pkg::RadW-1:0]   i_a,
    input  logic [sfr_pkg::DenW-1:0]   i_b,
    output logic [sfr_pkg::ProdW-1:0]  o_prod
);

    logic [sfr_pkg::ProdW-1:0] r_prod;

    // registered product
    always_ff @(posedge i_clk) begin
        r_prod <= sfr_pkg::ProdW'(i_a) * sfr_pkg::ProdW'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: hw/rtl/sfr_div.sv
// ----------------------------------------------------------------------------
// sfr_div: serial restoring divider
// Divides a 24 bit dividend by a 24 bit divisor, one quotient bit per
// cycle; busy from the start pulse until all 24 quotient bits are in.
// ----------------------------------------------------------------------------
module sfr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sfr_pkg::RadW-1:0]  i_dividend,
    input  logic [sfr_pkg::RadW-1:0]  i_divisor,
    output sfr_pkg::t_div_stat        o_stat
);

    logic                         r_busy;
    logic [sfr_pkg::DivCntW-1:0]  r_cnt;
    logic [sfr_pkg::RadW-1:0]     r_quo;
    logic [sfr_pkg::RadW-1:0]     r_rem;
    logic [sfr_pkg::RadW-1:0]     r_dvs;
    logic [sfr_pkg::RadW:0]       shifted;
    logic [sfr_pkg::RadW:0]       trial;
    logic                         fits;

    // one restoring step
    always_comb begin
        shifted = {r_rem, r_quo[sfr_pkg::RadW-1]};
        trial   = shifted - {1'b0, r_dvs};
        fits    = shifted >= {1'b0, r_dvs};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= sfr_pkg::DivCntW'(sfr_pkg::RadW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == sfr_pkg::DivCntW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[sfr_pkg::RadW-2:0], fits};
            r_rem <= fits ? trial[sfr_pkg::RadW-1:0] : shifted[sfr_pkg::RadW-1:0];
        end
    end

    assign o_stat.busy      = r_busy;
    assign o_stat.quotient  = r_quo;
    assign o_stat.remainder = r_rem;

endmodule

// File: hw/rtl/square_free_radical_split.sv
// ----------------------------------------------------------------------------
// square_free_radical_split: top level
// Writes sqrt(p/q) as (k/q)*sqrt(m) with m square-free, by trial division.
// ----------------------------------------------------------------------------
// One item at a time. After acceptance the block checks the operands (p or
// q zero, or q above the denominator limit, then one multiply for p*q
// compared with the radicand limit), then walks the trial divisors
// d = 2, 3, ... while d*d <= m. Each trial squares d on the shared
// multiplier, then divides m by d*d on the serial divider. Each square
// factor found costs one more trial of the same d, after m takes the
// quotient and k is multiplied by d. A rejected item skips the trials.
// The input stall is high from acceptance until the result has been
// loaded into the output register; a new item can be taken while that
// result waits.
// ----------------------------------------------------------------------------
module square_free_radical_split (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sfr_pkg::RadW-1:0]    i_radicand_num,
    input  logic [sfr_pkg::RadW-1:0]    i_radicand_den,
    input  logic                        i_negative_half,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_status,
    output logic [sfr_pkg::CoefW-1:0]   o_coeff_num,
    output logic [sfr_pkg::DenW-1:0]    o_coeff_den,
    output logic [sfr_pkg::RadW-1:0]    o_square_free_part,
    output logic                        o_no_root_left,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [0:0]                  i_cfg_index,
    input  logic [sfr_pkg::RadW-1:0]    i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_PQCHK = 9'b000000100,
        S_SQ    = 9'b000001000,
        S_SQCHK = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_UPD   = 9'b001000000,
        S_KMUL  = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state                       r_state, n_state;
    logic [sfr_pkg::RadW-1:0]     r_rad_limit;
    logic [sfr_pkg::DenW-1:0]     r_den_limit;
    logic [sfr_pkg::RadW-1:0]     r_p, n_p;
    logic [sfr_pkg::RadW-1:0]     r_q, n_q;
    logic [sfr_pkg::RadW-1:0]     r_m, n_m;
    logic [sfr_pkg::CoefW-1:0]    r_k, n_k;
    logic [sfr_pkg::RootW-1:0]    r_d, n_d;
    logic                         r_rej, n_rej;

    logic                         r_out_valid, n_out_valid;
    logic                         r_out_status;
    logic [sfr_pkg::CoefW-1:0]    r_out_k;
    logic [sfr_pkg::DenW-1:0]     r_out_q;
    logic [sfr_pkg::RadW-1:0]     r_out_m;
    logic                         r_out_unit;

    logic [sfr_pkg::RadW-1:0]     mul_a;
    logic [sfr_pkg::DenW-1:0]     mul_b;
    logic [sfr_pkg::ProdW-1:0]    mul_prod;
    logic                         div_start;
    sfr_pkg::t_div_stat           div_stat;

    logic                         in_xfer;
    logic                         out_xfer;
    logic                         load_out;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign load_out = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad_limit <= sfr_pkg::RadLimitReset;
            r_den_limit <= sfr_pkg::DenLimitReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (sfr_pkg::t_cfg_index'(i_cfg_index))
                sfr_pkg::CFG_RADICAND_LIMIT:    r_rad_limit <= i_cfg_data;
                sfr_pkg::CFG_DENOMINATOR_LIMIT: r_den_limit <= i_cfg_data[sfr_pkg::DenW-1:0];
                default: ;
            endcase
        end
    end

    // shared units
    sfr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    sfr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_m),
        .i_divisor  (mul_prod[sfr_pkg::RadW-1:0]),
        .o_stat     (div_stat)
    );

    // multiplier operand select
    always_comb begin
        case (r_state)
            S_SQ: begin
                mul_a = sfr_pkg::RadW'(r_d);
                mul_b = sfr_pkg::DenW'(r_d);
            end
            S_UPD: begin
                mul_a = sfr_pkg::RadW'(r_k);
                mul_b = sfr_pkg::DenW'(r_d);
            end
            default: begin
                mul_a = r_p;
                mul_b = r_q[sfr_pkg::DenW-1:0];
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_p       = r_p;
        n_q       = r_q;
        n_m       = r_m;
        n_k       = r_k;
        n_d       = r_d;
        n_rej     = r_rej;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_p     = i_negative_half ? i_radicand_den : i_radicand_num;
                    n_q     = i_negative_half ? i_radicand_num : i_radicand_den;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // product p*q is being formed this cycle
                if (r_p == '0 || r_q == '0 ||
                    r_q > sfr_pkg::RadW'(r_den_limit)) begin
                    n_rej   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_PQCHK;
                end
            end
            S_PQCHK: begin
                if (mul_prod > sfr_pkg::ProdW'(r_rad_limit)) begin
                    n_rej   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_rej   = 1'b0;
                    n_m     = mul_prod[sfr_pkg::RadW-1:0];
                    n_k     = sfr_pkg::CoefW'(1);
                    n_d     = sfr_pkg::RootW'(2);
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_SQCHK;
            end
            S_SQCHK: begin
                // stop once d*d exceeds what is left
                if (mul_prod > sfr_pkg::ProdW'(r_m)) begin
                    n_state = S_FIN;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_stat.busy) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (div_stat.remainder == '0) begin
                    n_m     = div_stat.quotient;
                    n_state = S_KMUL;
                end else begin
                    n_d     = r_d + 1'b1;
                    n_state = S_SQ;
                end
            end
            S_KMUL: begin
                // same d again: it may divide more than once
                n_k     = mul_prod[sfr_pkg::CoefW-1:0];
                n_state = S_SQ;
            end
            S_FIN: begin
                if (load_out) begin
                    n_rej   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rej   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rej   <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_q <= n_q;
        r_m <= n_m;
        r_k <= n_k;
        r_d <= n_d;
    end

    assign o_stall = (r_state != S_IDLE);

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_xfer) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_rej) begin
                r_out_status <= sfr_pkg::ST_REJECTED;
                r_out_k      <= '0;
                r_out_q      <= '0;
                r_out_m      <= '0;
                r_out_unit   <= 1'b0;
            end else begin
                r_out_status <= sfr_pkg::ST_DONE;
                r_out_k      <= r_k;
                r_out_q      <= r_q[sfr_pkg::DenW-1:0];
                r_out_m      <= r_m;
                r_out_unit   <= (r_m == sfr_pkg::RadW'(1));
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_coeff_num        = r_out_k;
    assign o_coeff_den        = r_out_q;
    assign o_square_free_part = r_out_m;
    assign o_no_root_left     = r_out_unit;

endmodule
